// ===== design/fba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_DEFRAG  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_BADREQ  = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ESCAN = 7'b0000010,
    S_RUN   = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_ESEL  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_DFILL = 7'b1000000
  } state_e;

  // What follows once the current bitmap sweep is complete.
  typedef enum logic [2:0] {
    J_ALLOC  = 3'd0,
    J_MOVE1  = 3'd1,
    J_MOVE2  = 3'd2,
    J_FREE   = 3'd3,
    J_SHRINK = 3'd4,
    J_GROW   = 3'd5
  } job_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] res;
    logic [7:0] src;
    logic [8:0] mlen;
    logic       moved;
    logic       last;
  } result_t;

  function automatic result_t mk_result(status_e st, logic [7:0] res);
    result_t r;
    r        = '0;
    r.status = st;
    r.res    = res;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/first_fit_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// First-fit pool allocator with an allocation table and compaction.
// Requests enter on the s_axis channel (operation in tuser, fields in tdata)
// and results leave on m_axis; tlast marks the final result of a request.
// Only one request is in work at a time; s_axis_tready is high while idle.
// The used/free bitmap sits in a RAM of 16-unit words (8 for tiny pools) and
// the table in a second RAM, each read one word or entry per cycle.
// A request takes a table scan, a bitmap search where it needs a new run and
// read-modify-write sweeps of the bitmap (a check sweep for growth in place,
// two for a move). Defrag makes one table pass per live entry, one more
// table pass and then a bitmap rewrite of one word a cycle. After reset the
// bitmap is cleared before the first request is taken. A finished result
// waits in the output register; a stalled receiver holds the block only when
// the next result is ready, and a new request can be taken while that result
// still waits.
module first_fit_bitmap_allocator_core
  import fba_pkg::*;
#(
  parameter int POOL_UNITS  = 256,
  parameter int MAX_ENTRIES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // offset [7:0], length [16:8], new_length [25:17], zero [31:26]
  input  wire  [31:0] s_axis_tdata,
  // operation [1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status [1:0], result_offset [9:2], source_offset [17:10],
  // move_length [26:18], moved [27], zero [31:28]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int W    = (POOL_UNITS >= 16) ? 16 : 8;
  localparam int LW   = $clog2(W);
  localparam int NW   = (POOL_UNITS + W - 1) / W;
  localparam int NWB  = (NW > 1) ? $clog2(NW) : 1;
  localparam int NWC  = $clog2(NW + 1);
  localparam int UW   = $clog2(POOL_UNITS + 1);
  localparam int EW   = $clog2(POOL_UNITS + 768);
  localparam int RNW  = $clog2(POOL_UNITS + W + 512);
  localparam int OW   = $clog2(POOL_UNITS);
  localparam int EIW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECW  = $clog2(MAX_ENTRIES + 1);
  localparam int EDW  = OW + 9;

  state_e           state_q, state_d, ret_q, ret_d;
  op_e              op_q, op_d;
  job_e             job_q, job_d;
  logic [7:0]       off_q, off_d;
  logic [8:0]       len_q, len_d, n_q, n_d;
  logic             alloc_q, alloc_d, def_q, def_d;
  logic [EIW-1:0]   slot_q, slot_d;
  logic [OW-1:0]    start_q, start_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d, done_q, done_d;
  logic [ECW-1:0]   cnt_q, cnt_d, k_q, k_d, ei_q, ei_d;
  logic [UW-1:0]    dest_q, dest_d;
  result_t          res_q, res_d, out_q, out_d;
  logic             out_v_q, out_v_d;
  logic             ep_v_q, ep_v_d;
  logic [EIW-1:0]   ep_idx_q, ep_idx_d, bidx_q, bidx_d;
  logic             bfound_q, bfound_d;
  logic [OW-1:0]    boff_q, boff_d;
  logic [8:0]       blen_q, blen_d;
  logic [NWC-1:0]   rw_q, rw_d, mw_q, mw_d, fw_q, fw_d;
  logic             rp_v_q, rp_v_d, mp_v_q, mp_v_d;
  logic [NWB-1:0]   rp_w_q, rp_w_d, mp_w_q, mp_w_d;
  logic [RNW-1:0]   run_q, run_d;
  logic [EW-1:0]    ms_q, ms_d, me_q, me_d;
  logic             mv_q, mv_d, chk_q, chk_d, mact_q, mact_d, fail_q, fail_d;

  logic             bm_we;
  logic [NWB-1:0]   bm_waddr, bm_raddr;
  logic [W-1:0]     bm_wdata, bm_rdata;
  logic             en_we;
  logic [EIW-1:0]   en_waddr, en_raddr;
  logic [EDW-1:0]   en_wdata, en_rdata;

  fba_ram #(.WIDTH(W), .DEPTH(NW)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  fba_ram #(.WIDTH(EDW), .DEPTH(MAX_ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (en_we),
    .waddr_i (en_waddr),
    .wdata_i (en_wdata),
    .raddr_i (en_raddr),
    .rdata_o (en_rdata)
  );

  logic [OW-1:0] e_off;
  logic [8:0]    e_len;
  logic [EW-1:0] off_e, dest_e, start_e, m_last;

  assign e_off   = en_rdata[OW-1:0];
  assign e_len   = en_rdata[EDW-1:OW];
  assign off_e   = EW'(off_q);
  assign dest_e  = EW'(dest_q);
  assign start_e = EW'(start_q);
  assign m_last  = (me_q - EW'(1)) >> LW;

  // Word masks for the sweep, the search and the defrag rewrite.
  logic [W-1:0] m_mask, fill_word, used_w;
  always_comb begin
    logic [EW-1:0] mi, fi, ri;
    for (int b = 0; b < W; b++) begin
      mi = (EW'(mp_w_q) << LW) + EW'(b);
      fi = (EW'(fw_q) << LW) + EW'(b);
      ri = (EW'(rp_w_q) << LW) + EW'(b);
      m_mask[b]    = (mi >= ms_q) && (mi < me_q);
      fill_word[b] = fi < dest_e;
      used_w[b]    = (ri >= EW'(POOL_UNITS)) || bm_rdata[b];
    end
  end

  // First position in this word where the free run reaches the request.
  logic           rf_hit;
  logic [LW-1:0]  rf_pos;
  logic [RNW-1:0] rf_run;
  logic [EW-1:0]  rf_start;
  always_comb begin
    logic [LW:0]    lst;
    logic [RNW-1:0] cur;
    rf_hit = 1'b0;
    rf_pos = '0;
    rf_run = '0;
    for (int j = 0; j < W; j++) begin
      lst = '0;
      for (int k = 0; k < W; k++) begin
        if (k <= j && used_w[k]) begin
          lst = (LW + 1)'(k + 1);
        end
      end
      if (lst == '0) begin
        cur = run_q + RNW'(j + 1);
      end else begin
        cur = RNW'(j + 1) - RNW'(lst);
      end
      if (!rf_hit && cur >= RNW'(n_q)) begin
        rf_hit = 1'b1;
        rf_pos = LW'(j);
      end
      if (j == W - 1) begin
        rf_run = cur;
      end
    end
    rf_start = (EW'(rp_w_q) << LW) + EW'(rf_pos) + EW'(1) - EW'(n_q);
  end

  logic in_acc;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    logic          ld_mark, ld_v, ld_chk, run_go, cand, f_found;
    logic [EW-1:0] ld_s, ld_e, ld_clip;
    logic [EIW-1:0] f_idx;
    logic [OW-1:0] f_off;
    logic [8:0]    f_len;
    logic [8:0]    in_len, in_n;
    op_e           in_op;

    state_d  = state_q;  ret_d    = ret_q;   op_d     = op_q;    job_d  = job_q;
    off_d    = off_q;    len_d    = len_q;   n_d      = n_q;     alloc_d = alloc_q;
    def_d    = def_q;    slot_d   = slot_q;  start_d  = start_q;
    valid_d  = valid_q;  done_d   = done_q;  cnt_d    = cnt_q;   k_d    = k_q;
    ei_d     = ei_q;     dest_d   = dest_q;  res_d    = res_q;   out_d  = out_q;
    ep_v_d   = ep_v_q;   ep_idx_d = ep_idx_q; bidx_d  = bidx_q;  bfound_d = bfound_q;
    boff_d   = boff_q;   blen_d   = blen_q;  rw_d     = rw_q;    mw_d   = mw_q;
    fw_d     = fw_q;     rp_v_d   = rp_v_q;  mp_v_d   = mp_v_q;  rp_w_d = rp_w_q;
    mp_w_d   = mp_w_q;   run_d    = run_q;   ms_d     = ms_q;    me_d   = me_q;
    mv_d     = mv_q;     chk_d    = chk_q;   mact_d   = mact_q;  fail_d = fail_q;
    out_v_d  = out_v_q && !m_axis_tready;

    ld_mark = 1'b0; ld_v = 1'b0; ld_chk = 1'b0; ld_s = '0; ld_e = '0; run_go = 1'b0;
    cand = 1'b0; f_found = 1'b0; f_idx = bidx_q; f_off = boff_q; f_len = blen_q;
    ld_clip = '0;
    in_op  = op_e'(s_axis_tuser);
    in_len = s_axis_tdata[16:8];
    in_n   = s_axis_tdata[25:17];

    bm_we = 1'b0; bm_waddr = mp_w_q; bm_wdata = '0; bm_raddr = '0;
    en_we = 1'b0; en_waddr = slot_q; en_wdata = {n_q, start_q}; en_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d   = in_op;
          off_d  = s_axis_tdata[7:0];
          len_d  = in_len;
          n_d    = in_n;
          ei_d   = '0;
          ep_v_d = 1'b0;
          if (in_op == OP_DEFRAG) begin
            bfound_d = 1'b0;
            done_d   = '0;
            k_d      = '0;
            dest_d   = '0;
            def_d    = 1'b1;
            state_d  = S_ESEL;
          end else if (in_op == OP_ALLOC || (in_op == OP_REALLOC && in_len == '0)) begin
            alloc_d = 1'b1;
            if (in_n == '0) begin
              res_d   = mk_result(ST_BADREQ, 8'd0);
              ret_d   = S_IDLE;
              state_d = S_EMIT;
            end else begin
              state_d = S_ESCAN;
            end
          end else begin
            alloc_d = 1'b0;
            state_d = S_ESCAN;
          end
        end
      end

      S_ESCAN: begin
        if (ei_q < ECW'(MAX_ENTRIES)) begin
          en_raddr = ei_q[EIW-1:0];
          ep_v_d   = 1'b1;
          ep_idx_d = ei_q[EIW-1:0];
          ei_d     = ei_q + ECW'(1);
        end else begin
          ep_v_d = 1'b0;
        end
        if (ep_v_q) begin
          if (alloc_q) begin
            cand = !valid_q[ep_idx_q];
          end else begin
            cand = valid_q[ep_idx_q] && (EW'(e_off) == off_e) && (e_len == len_q);
          end
          if (cand) begin
            slot_d = ep_idx_q;
            ep_v_d = 1'b0;
            if (alloc_q) begin
              run_go = 1'b1;
            end else if (op_q == OP_FREE) begin
              ld_mark = 1'b1;
              ld_s    = off_e;
              ld_e    = off_e + EW'(len_q);
              job_d   = J_FREE;
            end else if (n_q <= len_q) begin
              ld_mark = 1'b1;
              ld_s    = off_e + EW'(n_q);
              ld_e    = off_e + EW'(len_q);
              job_d   = J_SHRINK;
            end else if (off_e + EW'(n_q) <= EW'(POOL_UNITS)) begin
              // Growth in place needs the units just past the end to be free.
              ld_mark = 1'b1;
              ld_chk  = 1'b1;
              ld_s    = off_e + EW'(len_q);
              ld_e    = off_e + EW'(n_q);
            end else begin
              run_go = 1'b1;
            end
          end else if (ep_idx_q == EIW'(MAX_ENTRIES - 1)) begin
            res_d   = mk_result(alloc_q ? ST_BADREQ : ST_BADFREE, 8'd0);
            ret_d   = S_IDLE;
            state_d = S_EMIT;
          end
        end
      end

      S_RUN: begin
        if (rw_q < NWC'(NW)) begin
          bm_raddr = rw_q[NWB-1:0];
          rp_v_d   = 1'b1;
          rp_w_d   = rw_q[NWB-1:0];
          rw_d     = rw_q + NWC'(1);
        end else begin
          rp_v_d = 1'b0;
        end
        if (rp_v_q) begin
          if (rf_hit) begin
            start_d = rf_start[OW-1:0];
            ld_mark = 1'b1;
            ld_v    = 1'b1;
            ld_s    = rf_start;
            ld_e    = rf_start + EW'(n_q);
            job_d   = alloc_q ? J_ALLOC : J_MOVE1;
          end else begin
            run_d = rf_run;
            if (rp_w_q == NWB'(NW - 1)) begin
              res_d   = mk_result(ST_NOMEM, 8'd0);
              ret_d   = S_IDLE;
              state_d = S_EMIT;
            end
          end
        end
      end

      S_MARK: begin
        if (mact_q) begin
          bm_raddr = mw_q[NWB-1:0];
          mp_v_d   = 1'b1;
          mp_w_d   = mw_q[NWB-1:0];
          mw_d     = mw_q + NWC'(1);
          if (EW'(mw_q) == m_last) begin
            mact_d = 1'b0;
          end
        end else begin
          mp_v_d = 1'b0;
        end
        if (mp_v_q) begin
          if (chk_q) begin
            if (|(bm_rdata & m_mask)) begin
              fail_d = 1'b1;
            end
          end else begin
            bm_we    = 1'b1;
            bm_waddr = mp_w_q;
            bm_wdata = mv_q ? (bm_rdata | m_mask) : (bm_rdata & ~m_mask);
          end
        end
        if (!mact_q && !mp_v_q) begin
          if (chk_q) begin
            if (fail_q) begin
              run_go = 1'b1;
            end else begin
              ld_mark = 1'b1;
              ld_v    = 1'b1;
              ld_s    = off_e + EW'(len_q);
              ld_e    = off_e + EW'(n_q);
              job_d   = J_GROW;
            end
          end else begin
            ret_d = S_IDLE;
            case (job_q)
              J_ALLOC: begin
                en_we           = 1'b1;
                valid_d[slot_q] = 1'b1;
                cnt_d           = cnt_q + ECW'(1);
                res_d           = mk_result(ST_OK, start_e[7:0]);
                state_d         = S_EMIT;
              end
              J_MOVE1: begin
                // New run is held; now release the old one.
                ld_mark = 1'b1;
                ld_s    = off_e;
                ld_e    = off_e + EW'(len_q);
                job_d   = J_MOVE2;
              end
              J_MOVE2: begin
                en_we       = 1'b1;
                res_d       = mk_result(ST_OK, start_e[7:0]);
                res_d.src   = off_q;
                res_d.mlen  = len_q;
                res_d.moved = 1'b1;
                state_d     = S_EMIT;
              end
              J_FREE: begin
                valid_d[slot_q] = 1'b0;
                cnt_d           = cnt_q - ECW'(1);
                res_d           = mk_result(ST_OK, off_q);
                state_d         = S_EMIT;
              end
              J_SHRINK: begin
                if (n_q == '0) begin
                  valid_d[slot_q] = 1'b0;
                  cnt_d           = cnt_q - ECW'(1);
                end else begin
                  en_we    = 1'b1;
                  en_wdata = {n_q, off_e[OW-1:0]};
                end
                res_d   = mk_result(ST_OK, off_q);
                state_d = S_EMIT;
              end
              J_GROW: begin
                en_we    = 1'b1;
                en_wdata = {n_q, off_e[OW-1:0]};
                res_d    = mk_result(ST_OK, off_q);
                state_d  = S_EMIT;
              end
              default: begin
                state_d = S_IDLE;
              end
            endcase
          end
        end
      end

      S_ESEL: begin
        if (ei_q < ECW'(MAX_ENTRIES)) begin
          en_raddr = ei_q[EIW-1:0];
          ep_v_d   = 1'b1;
          ep_idx_d = ei_q[EIW-1:0];
          ei_d     = ei_q + ECW'(1);
        end else begin
          ep_v_d = 1'b0;
        end
        if (ep_v_q) begin
          cand    = valid_q[ep_idx_q] && !done_q[ep_idx_q] && (!bfound_q || e_off < boff_q);
          f_found = bfound_q || cand;
          if (cand) begin
            f_idx = ep_idx_q;
            f_off = e_off;
            f_len = e_len;
          end
          bfound_d = f_found;
          bidx_d   = f_idx;
          boff_d   = f_off;
          blen_d   = f_len;
          if (ep_idx_q == EIW'(MAX_ENTRIES - 1)) begin
            ei_d     = '0;
            ep_v_d   = 1'b0;
            bfound_d = 1'b0;
            if (f_found) begin
              done_d[f_idx] = 1'b1;
              en_we         = 1'b1;
              en_waddr      = f_idx;
              en_wdata      = {f_len, dest_e[OW-1:0]};
              k_d           = k_q + ECW'(1);
              dest_d        = dest_q + UW'(f_len);
              res_d         = '0;
              res_d.status  = ST_OK;
              res_d.res     = dest_e[7:0];
              res_d.last    = (k_q + ECW'(1)) == cnt_q;
              if (EW'(f_off) != dest_e) begin
                res_d.src   = 8'(EW'(f_off));
                res_d.mlen  = f_len;
                res_d.moved = 1'b1;
              end
              ret_d   = S_ESEL;
              state_d = S_EMIT;
            end else begin
              fw_d    = '0;
              state_d = S_DFILL;
            end
          end
        end
      end

      S_EMIT: begin
        if (!out_v_q || m_axis_tready) begin
          out_d   = res_q;
          out_v_d = 1'b1;
          state_d = ret_q;
        end
      end

      S_DFILL: begin
        bm_we    = 1'b1;
        bm_waddr = fw_q[NWB-1:0];
        bm_wdata = fill_word;
        fw_d     = fw_q + NWC'(1);
        if (fw_q == NWC'(NW - 1)) begin
          def_d = 1'b0;
          if (def_q && k_q == '0) begin
            res_d   = mk_result(ST_OK, 8'd0);
            ret_d   = S_IDLE;
            state_d = S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ld_mark) begin
      ld_clip = (ld_e > EW'(POOL_UNITS)) ? EW'(POOL_UNITS) : ld_e;
      ms_d    = ld_s;
      me_d    = ld_clip;
      mv_d    = ld_v;
      chk_d   = ld_chk;
      fail_d  = 1'b0;
      mp_v_d  = 1'b0;
      mw_d    = NWC'(ld_s >> LW);
      mact_d  = ld_s < ld_clip;
      state_d = S_MARK;
    end

    if (run_go) begin
      if (EW'(n_q) > EW'(POOL_UNITS)) begin
        res_d   = mk_result(ST_NOMEM, 8'd0);
        ret_d   = S_IDLE;
        state_d = S_EMIT;
      end else begin
        rw_d    = '0;
        rp_v_d  = 1'b0;
        run_d   = '0;
        state_d = S_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_DFILL;
      ret_q    <= S_IDLE;
      job_q    <= J_ALLOC;
      op_q     <= OP_ALLOC;
      alloc_q  <= 1'b0;
      def_q    <= 1'b0;
      valid_q  <= '0;
      done_q   <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      ei_q     <= '0;
      dest_q   <= '0;
      out_v_q  <= 1'b0;
      ep_v_q   <= 1'b0;
      bfound_q <= 1'b0;
      rw_q     <= '0;
      mw_q     <= '0;
      fw_q     <= '0;
      rp_v_q   <= 1'b0;
      mp_v_q   <= 1'b0;
      chk_q    <= 1'b0;
      mact_q   <= 1'b0;
      fail_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      job_q    <= job_d;
      op_q     <= op_d;
      alloc_q  <= alloc_d;
      def_q    <= def_d;
      valid_q  <= valid_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      ei_q     <= ei_d;
      dest_q   <= dest_d;
      out_v_q  <= out_v_d;
      ep_v_q   <= ep_v_d;
      bfound_q <= bfound_d;
      rw_q     <= rw_d;
      mw_q     <= mw_d;
      fw_q     <= fw_d;
      rp_v_q   <= rp_v_d;
      mp_v_q   <= mp_v_d;
      chk_q    <= chk_d;
      mact_q   <= mact_d;
      fail_q   <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    len_q    <= len_d;
    n_q      <= n_d;
    slot_q   <= slot_d;
    start_q  <= start_d;
    res_q    <= res_d;
    out_q    <= out_d;
    ep_idx_q <= ep_idx_d;
    bidx_q   <= bidx_d;
    boff_q   <= boff_d;
    blen_q   <= blen_d;
    rp_w_q   <= rp_w_d;
    mp_w_q   <= mp_w_d;
    run_q    <= run_d;
    ms_q     <= ms_d;
    me_q     <= me_d;
    mv_q     <= mv_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0000, out_q.moved, out_q.mlen, out_q.src, out_q.res,
                          out_q.status};
  assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

// ===== design/fba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire                                    clk_i,
  input  wire                                    we_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                       wdata_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
